FILE: hdl/rsle_pkg.sv
// Shared constants for the raw string literal end scanner.
// Character codes, result codes and parameter defaults; no dependencies.
`timescale 1ns / 1ps

package rsle_pkg;

	// Width of the position and length fields on the ports.
	localparam int FIELD_W = 32;

	// Parameter defaults for the top level.
	localparam int MAX_DELIMITER_DEF  = 16;
	localparam int POSITION_WIDTH_DEF = 32;

	// Result codes.
	localparam logic [1:0] OUT_NOT_RAW = 2'd0;
	localparam logic [1:0] OUT_FOUND   = 2'd1;
	localparam logic [1:0] OUT_BAD     = 2'd2;

	// Character codes used by the prefix and delimiter rules.
	localparam logic [7:0] CH_LOWER_U = 8'h75;
	localparam logic [7:0] CH_UPPER_U = 8'h55;
	localparam logic [7:0] CH_UPPER_L = 8'h4C;
	localparam logic [7:0] CH_UPPER_R = 8'h52;
	localparam logic [7:0] CH_EIGHT   = 8'h38;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	// Characters that may not appear in a delimiter.
	function automatic logic bad_delim_char(input logic [7:0] c);
		return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_BSLASH ||
		       c == CH_RPAREN || c == CH_QUOTE;
	endfunction

endpackage

FILE: hdl/raw_string_literal_end_scanner.sv
// Raw string literal end scanner: prefix check, delimiter capture and terminator search.
// Depends on rsle_pkg for character codes, result codes and parameter defaults.
// Results are registered: each is loaded as its character is taken. The delimiter
// memory reads ahead, so one character per cycle is taken unless a held result stalls.
// Reset: arst_n clears the scan state to idle and empties the output register; the
// delimiter memory is not cleared, since only entries written in the current scan are read.
`timescale 1ns / 1ps

module raw_string_literal_end_scanner #(
	parameter int MAX_DELIMITER  = rsle_pkg::MAX_DELIMITER_DEF,
	parameter int POSITION_WIDTH = rsle_pkg::POSITION_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   ch,
	input  logic [rsle_pkg::FIELD_W-1:0] char_index,
	input  logic [rsle_pkg::FIELD_W-1:0] text_length,
	input  logic                         begin_req,
	input  logic                         prev_ident,
	input  logic                         beyond_end,
	input  logic                         final_char,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rsle_pkg::FIELD_W-1:0] end_position,
	output logic [1:0]                   outcome
);
	import rsle_pkg::*;

	// Width of the delimiter length (0 .. MAX_DELIMITER), of the match position
	// (0 .. MAX_DELIMITER + 1) and of a memory address.
	localparam int DLW = $clog2(MAX_DELIMITER + 1);
	localparam int MW  = $clog2(MAX_DELIMITER + 2);
	localparam int AW  = (MAX_DELIMITER > 1) ? $clog2(MAX_DELIMITER) : 1;

	// Reported positions are wrapped to POSITION_WIDTH bits, and never exceed the port width.
	localparam logic [FIELD_W-1:0] POS_MASK =
		(POSITION_WIDTH >= FIELD_W) ? {FIELD_W{1'b1}} :
		FIELD_W'((64'd1 << POSITION_WIDTH) - 64'd1);

	// Scan phases.
	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_PREFIX = 3'd1;
	localparam logic [2:0] PH_DELIM  = 3'd2;
	localparam logic [2:0] PH_SEARCH = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	// Progress through the prefix: nothing yet, 'u', 'U' or 'L', 'R', "u8".
	localparam logic [2:0] PP_NONE = 3'd0;
	localparam logic [2:0] PP_U    = 3'd1;
	localparam logic [2:0] PP_UL   = 3'd2;
	localparam logic [2:0] PP_R    = 3'd3;
	localparam logic [2:0] PP_U8   = 3'd4;

	logic [2:0]     phase_q;
	logic [2:0]     pp_q;
	logic [DLW-1:0] dlen_q;
	logic [MW-1:0]  mp_q;

	// The delimiter store and its registered read port. While searching, the byte
	// for the next expected match position is fetched at the edge that takes the
	// current character, so it is waiting when the next character arrives. Writes
	// happen only while the delimiter is captured and reads only while searching,
	// so the two ports never touch the same entry in one cycle.
	logic [7:0]     delim_mem [MAX_DELIMITER];
	logic [7:0]     rd_data_q;

	logic           out_valid_q;
	logic [FIELD_W-1:0] end_pos_q;
	logic [1:0]     outcome_q;

	logic           in_accept;
	logic           res_v;
	logic [FIELD_W-1:0] res_pos;
	logic [1:0]     res_code;

	logic [2:0]     eff_phase, nxt_phase;
	logic [2:0]     eff_pp, nxt_pp;
	logic [DLW-1:0] eff_dlen, nxt_dlen;
	logic [MW-1:0]  eff_mp, nxt_mp;
	logic [MW-1:0]  dlen_ext;
	logic [MW-1:0]  rd_pos;
	logic [7:0]     expect_ch;
	logic           wr_en;
	logic           rd_en;

	// The output register parts the two sides: a new character is taken whenever
	// the held result is either absent or leaving in this cycle.
	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		res_v     = 1'b0;
		res_pos   = '0;
		res_code  = OUT_NOT_RAW;
		wr_en     = 1'b0;
		expect_ch = CH_RPAREN;

		// A begin request restarts the scan, dropping any scan in progress.
		eff_phase = phase_q;
		eff_pp    = pp_q;
		eff_dlen  = dlen_q;
		eff_mp    = mp_q;
		if (begin_req) begin
			eff_phase = PH_PREFIX;
			eff_pp    = PP_NONE;
			eff_dlen  = '0;
			eff_mp    = '0;
		end
		nxt_phase = eff_phase;
		nxt_pp    = eff_pp;
		nxt_dlen  = eff_dlen;
		nxt_mp    = eff_mp;
		dlen_ext  = MW'(eff_dlen);

		if (begin_req && (beyond_end || prev_ident)) begin
			// Rejected start: past the end, or inside an identifier.
			res_v = 1'b1;
		end else begin
			case (eff_phase)
				PH_PREFIX: begin
					case (eff_pp)
						PP_NONE: begin
							if (ch == CH_LOWER_U) begin
								nxt_pp = PP_U;
							end else if (ch == CH_UPPER_U || ch == CH_UPPER_L) begin
								nxt_pp = PP_UL;
							end else if (ch == CH_UPPER_R) begin
								nxt_pp = PP_R;
							end else begin
								res_v = 1'b1;
							end
						end
						PP_U: begin
							if (ch == CH_EIGHT) begin
								nxt_pp = PP_U8;
							end else if (ch == CH_UPPER_R) begin
								nxt_pp = PP_R;
							end else begin
								res_v = 1'b1;
							end
						end
						PP_UL, PP_U8: begin
							if (ch == CH_UPPER_R) begin
								nxt_pp = PP_R;
							end else begin
								res_v = 1'b1;
							end
						end
						PP_R: begin
							if (ch == CH_QUOTE) begin
								nxt_phase = PH_DELIM;
								nxt_dlen  = '0;
							end else begin
								res_v = 1'b1;
							end
						end
						default: begin
							res_v = 1'b1;
						end
					endcase
					if (!res_v && final_char) begin
						res_v = 1'b1;
						// A text that ends right after the opening quote is unterminated.
						if (eff_pp == PP_R) begin
							res_pos  = text_length & POS_MASK;
							res_code = OUT_BAD;
						end
					end
				end
				PH_DELIM: begin
					if (ch == CH_LPAREN) begin
						nxt_phase = PH_SEARCH;
						nxt_mp    = '0;
					end else if (bad_delim_char(ch) || eff_dlen >= DLW'(MAX_DELIMITER)) begin
						res_v = 1'b1;
					end else begin
						wr_en    = 1'b1;
						nxt_dlen = eff_dlen + DLW'(1);
					end
					if (final_char) begin
						res_v = 1'b1;
					end
					if (res_v) begin
						res_pos  = text_length & POS_MASK;
						res_code = OUT_BAD;
					end
				end
				PH_SEARCH: begin
					// Expected: ')' first, then each delimiter byte, then the quote.
					if (eff_mp == '0) begin
						expect_ch = CH_RPAREN;
					end else if (eff_mp <= dlen_ext) begin
						expect_ch = rd_data_q;
					end else begin
						expect_ch = CH_QUOTE;
					end
					if (ch == expect_ch) begin
						if (eff_mp >= dlen_ext + MW'(1)) begin
							res_v    = 1'b1;
							res_pos  = (char_index + FIELD_W'(1)) & POS_MASK;
							res_code = OUT_FOUND;
						end else begin
							nxt_mp = eff_mp + MW'(1);
						end
					end else begin
						// A stray ')' may itself open the terminator.
						nxt_mp = (ch == CH_RPAREN) ? MW'(1) : '0;
					end
					if (!res_v && final_char) begin
						res_v    = 1'b1;
						res_pos  = text_length & POS_MASK;
						res_code = OUT_BAD;
					end
				end
				default: begin
					// Idle or finished: characters are ignored until the next begin.
				end
			endcase
		end

		if (res_v) begin
			nxt_phase = PH_DONE;
		end
	end

	// Read-ahead for the next character while searching.
	assign rd_pos = nxt_mp - MW'(1);
	assign rd_en  = in_accept && nxt_phase == PH_SEARCH && nxt_mp != '0 &&
	                nxt_mp <= MW'(nxt_dlen);

	always_ff @(posedge clk) begin
		if (in_accept && wr_en) begin
			delim_mem[eff_dlen[AW-1:0]] <= ch;
		end
		if (rd_en) begin
			rd_data_q <= delim_mem[rd_pos[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			pp_q    <= PP_NONE;
			dlen_q  <= '0;
			mp_q    <= '0;
		end else if (in_accept) begin
			phase_q <= nxt_phase;
			pp_q    <= nxt_pp;
			dlen_q  <= nxt_dlen;
			mp_q    <= nxt_mp;
		end
	end

	// Output register: loaded by a result, emptied when the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept && res_v) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && res_v) begin
			end_pos_q <= res_pos;
			outcome_q <= res_code;
		end
	end

	assign out_valid    = out_valid_q;
	assign end_position = end_pos_q;
	assign outcome      = outcome_q;

	// A held result that is stalled must hold the input back as well.
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> in_stall)
		else $error("input taken while a stalled result is held");

	// The match position never runs past the closing quote of the terminator.
	a_match_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mp_q <= MW'(dlen_q) + MW'(1))
		else $error("match position beyond terminator length");

	// The captured delimiter never exceeds its limit.
	a_delim_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dlen_q <= DLW'(MAX_DELIMITER))
		else $error("delimiter length beyond limit");

	// Every result ends the scan and lands in the output register.
	a_result_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && res_v |=> phase_q == PH_DONE && out_valid_q)
		else $error("result did not end the scan");

endmodule

FILE: verif/literal_end_check_pkg.sv
// Item types and the scoreboard for the raw string literal end scanner testbench.
// Depends on rsle_pkg for character codes, result codes and the delimiter limit.
`timescale 1ns / 1ps

package literal_end_check_pkg;

	import rsle_pkg::*;

	localparam int MAX_DELIM = MAX_DELIMITER_DEF;

	typedef logic [7:0] text_q_t[$];

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_PREFIX,
		SCAN_DELIM,
		SCAN_SEARCH,
		SCAN_DONE
	} scan_phase_e;

	typedef enum logic [2:0] {
		PFX_NONE,
		PFX_U,
		PFX_UL,
		PFX_R,
		PFX_U8,
		PFX_BAD
	} prefix_e;

	typedef struct {
		logic [7:0]         chr;
		logic [FIELD_W-1:0] pos;
		logic [FIELD_W-1:0] text_len;
		bit                 start;
		bit                 prev_ident;
		bit                 beyond;
		bit                 last;
	} char_item_t;

	typedef struct {
		logic [FIELD_W-1:0] end_position;
		logic [1:0]         outcome;
	} literal_end_t;

	function automatic bit delim_char_forbidden(input logic [7:0] c);
		return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE || c == CH_BSLASH ||
			c == CH_RPAREN || c == CH_QUOTE;
	endfunction

	class literal_end_scoreboard;
		scan_phase_e  phase;
		prefix_e      prefix_seen;
		logic [7:0]   delim_store [MAX_DELIM];
		int           delim_len;
		int           match_len;
		literal_end_t pending_ends[$];
		int           failures;
		int           scanned_chars;

		function new();
			phase = SCAN_IDLE;
			prefix_seen = PFX_NONE;
			delim_len = 0;
			match_len = 0;
			failures = 0;
			scanned_chars = 0;
		endfunction

		function void close_scan(input logic [FIELD_W-1:0] end_pos, input logic [1:0] code);
			literal_end_t r;
			r.end_position = end_pos;
			r.outcome = code;
			pending_ends.push_back(r);
			phase = SCAN_DONE;
		endfunction

		// Advances the scan by one accepted character and queues any end it produces.
		function void take_char(input char_item_t it);
			logic [7:0] want;
			prefix_e    next_pfx;
			if (!it.start && (phase == SCAN_IDLE || phase == SCAN_DONE))
				return;
			scanned_chars++;
			if (it.start) begin
				if (it.beyond || it.prev_ident) begin
					close_scan('0, OUT_NOT_RAW);
					return;
				end
				phase = SCAN_PREFIX;
				prefix_seen = PFX_NONE;
				delim_len = 0;
				match_len = 0;
			end
			case (phase)
				SCAN_PREFIX: begin
					next_pfx = PFX_BAD;
					case (prefix_seen)
						PFX_NONE: begin
							if (it.chr == CH_LOWER_U)
								next_pfx = PFX_U;
							else if (it.chr == CH_UPPER_U || it.chr == CH_UPPER_L)
								next_pfx = PFX_UL;
							else if (it.chr == CH_UPPER_R)
								next_pfx = PFX_R;
						end
						PFX_U: begin
							if (it.chr == CH_EIGHT)
								next_pfx = PFX_U8;
							else if (it.chr == CH_UPPER_R)
								next_pfx = PFX_R;
						end
						PFX_UL, PFX_U8: begin
							if (it.chr == CH_UPPER_R)
								next_pfx = PFX_R;
						end
						PFX_R: begin
							if (it.chr == CH_QUOTE) begin
								phase = SCAN_DELIM;
								delim_len = 0;
								if (it.last)
									close_scan(it.text_len, OUT_BAD);
								return;
							end
						end
						default: ;
					endcase
					if (next_pfx == PFX_BAD || it.last)
						close_scan('0, OUT_NOT_RAW);
					else
						prefix_seen = next_pfx;
				end
				SCAN_DELIM: begin
					if (it.chr == CH_LPAREN) begin
						phase = SCAN_SEARCH;
						match_len = 0;
					end else if (delim_char_forbidden(it.chr) || delim_len >= MAX_DELIM) begin
						close_scan(it.text_len, OUT_BAD);
						return;
					end else begin
						delim_store[delim_len] = it.chr;
						delim_len++;
					end
					if (it.last)
						close_scan(it.text_len, OUT_BAD);
				end
				SCAN_SEARCH: begin
					if (match_len == 0)
						want = CH_RPAREN;
					else if (match_len <= delim_len)
						want = delim_store[match_len - 1];
					else
						want = CH_QUOTE;
					if (it.chr == want) begin
						if (match_len >= delim_len + 1) begin
							close_scan(it.pos + 32'd1, OUT_FOUND);
							return;
						end
						match_len++;
					end else begin
						match_len = (it.chr == CH_RPAREN) ? 1 : 0;
					end
					if (it.last)
						close_scan(it.text_len, OUT_BAD);
				end
				default: ;
			endcase
		endfunction

		function void check_end(input logic [FIELD_W-1:0] end_pos, input logic [1:0] code);
			literal_end_t want;
			if (pending_ends.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual end_position 0x%08h outcome %0d",
					$time, end_pos, code);
				failures++;
				return;
			end
			want = pending_ends.pop_front();
			if (end_pos !== want.end_position) begin
				$display("%0t: end_position expected 0x%08h, actual 0x%08h",
					$time, want.end_position, end_pos);
				failures++;
			end
			if (code !== want.outcome) begin
				$display("%0t: outcome expected %0d, actual %0d", $time, want.outcome, code);
				failures++;
			end
		endfunction
	endclass

endpackage

FILE: verif/tb.sv
// Testbench for raw_string_literal_end_scanner: drives character streams and checks each end.
// Depends on rsle_pkg and on literal_end_check_pkg for item types and the scoreboard.
`timescale 1ns / 1ps

module tb;

	import rsle_pkg::*;
	import literal_end_check_pkg::*;

	// Cycles with no transaction on either channel before the run is declared hung.
	localparam int STUCK_LIMIT = 1000;
	localparam int TARGET_CHARS = 1150;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [7:0]          ch;
	logic [FIELD_W-1:0]  char_index;
	logic [FIELD_W-1:0]  text_length;
	logic                begin_req;
	logic                prev_ident;
	logic                beyond_end;
	logic                final_char;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [FIELD_W-1:0]  end_position;
	logic [1:0]          outcome;

	// Position and text length used for the characters of the scan in progress.
	logic [FIELD_W-1:0]  scan_pos;
	logic [FIELD_W-1:0]  scan_len;
	// While set, neither side inserts gaps or stalls.
	bit                  quiet = 1'b0;
	int                  stuck_cycles = 0;

	literal_end_scoreboard board;

	raw_string_literal_end_scanner dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.ch           (ch),
		.char_index   (char_index),
		.text_length  (text_length),
		.begin_req    (begin_req),
		.prev_ident   (prev_ident),
		.beyond_end   (beyond_end),
		.final_char   (final_char),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.end_position (end_position),
		.outcome      (outcome)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiving side stalls at random, changing only on the falling edge.
	always @(negedge clk) begin
		out_stall <= !quiet && ($urandom_range(0, 99) < 28);
	end

	// Every result transaction is compared with the oldest predicted end.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_end(end_position, outcome);
	end

	// The watchdog is cleared by any transaction, so it only fires when the block hangs.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles == STUCK_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Presents one character and waits for its transaction. Called at a falling edge and
	// returns at the falling edge after the transaction, so valid is assigned at most once per time step.
	task automatic put(input logic [7:0] c, input bit start, input bit pid, input bit beyond,
		input bit last);
		char_item_t it;
		it.chr = c;
		it.pos = scan_pos;
		it.text_len = scan_len;
		it.start = start;
		it.prev_ident = pid;
		it.beyond = beyond;
		it.last = last;
		while (!quiet && $urandom_range(0, 99) < 28) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		char_index <= scan_pos;
		text_length <= scan_len;
		begin_req <= start;
		prev_ident <= pid;
		beyond_end <= beyond;
		final_char <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.take_char(it);
		scan_pos = scan_pos + 32'd1;
		@(negedge clk);
	endtask

	// Sends a text as one scan: the first character carries the begin request.
	task automatic send_text(input text_q_t txt, input bit mark_last);
		for (int i = 0; i < txt.size(); i++)
			put(txt[i], i == 0, 1'b0, 1'b0, mark_last && i == txt.size() - 1);
	endtask

	// Picks a start position and a text length; a quarter of each are full-width random so
	// that every bit of both fields toggles.
	task automatic open_scan();
		scan_pos = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 5000);
		scan_len = ($urandom_range(0, 3) == 0) ? $urandom : scan_pos + $urandom_range(0, 400);
	endtask

	function automatic text_q_t prefix_text(input int kind);
		text_q_t t;
		case (kind)
			0: t = {CH_UPPER_R};
			1: t = {CH_LOWER_U, CH_UPPER_R};
			2: t = {CH_UPPER_U, CH_UPPER_R};
			3: t = {CH_UPPER_L, CH_UPPER_R};
			default: t = {CH_LOWER_U, CH_EIGHT, CH_UPPER_R};
		endcase
		t.push_back(CH_QUOTE);
		return t;
	endfunction

	// Any byte that is allowed inside a delimiter, high bytes included.
	function automatic logic [7:0] delim_byte();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (delim_char_forbidden(c) || c == CH_LPAREN);
		return c;
	endfunction

	function automatic logic [7:0] forbidden_byte();
		int k;
		k = $urandom_range(0, 8);
		case (k)
			5: return CH_SPACE;
			6: return CH_BSLASH;
			7: return CH_RPAREN;
			8: return CH_QUOTE;
			default: return CH_TAB + 8'(k);
		endcase
	endfunction

	// A well-formed literal with random content, then finished in one of several ways:
	// complete, cut short at the end of the text, interrupted by the next begin, or with
	// a broken or over-long delimiter.
	task automatic raw_literal_scan();
		text_q_t txt;
		text_q_t delim;
		int      mode;
		int      dlen;
		int      j;
		int      k;
		open_scan();
		txt = prefix_text($urandom_range(0, 4));
		mode = $urandom_range(0, 99);
		dlen = ($urandom_range(0, 5) == 0) ? MAX_DELIM : $urandom_range(0, 4);
		if (mode >= 90)
			dlen = MAX_DELIM + 1 + $urandom_range(0, 2);
		repeat (dlen)
			delim.push_back(delim_byte());
		if (mode >= 80 && mode < 90)
			delim.insert($urandom_range(0, delim.size()), forbidden_byte());
		txt = {txt, delim};
		txt.push_back(CH_LPAREN);
		repeat ($urandom_range(0, 12)) begin
			if ($urandom_range(0, 4) == 0) begin
				// A near miss: a closing parenthesis and the start of the delimiter.
				txt.push_back(CH_RPAREN);
				j = $urandom_range(0, delim.size());
				for (k = 0; k < j; k++)
					txt.push_back(delim[k]);
			end else begin
				txt.push_back(8'($urandom));
			end
		end
		txt.push_back(CH_RPAREN);
		txt = {txt, delim};
		txt.push_back(CH_QUOTE);
		if (mode < 55) begin
			send_text(txt, $urandom_range(0, 2) == 0);
			// Characters after the end without a begin are dropped by the block.
			repeat ($urandom_range(0, 2))
				put(8'($urandom), 1'b0, 1'($urandom), 1'($urandom), 1'($urandom));
		end else if (mode < 80) begin
			txt = txt[0:$urandom_range(0, txt.size() - 2)];
			send_text(txt, mode < 70);
		end else begin
			send_text(txt, 1'($urandom));
		end
	endtask

	// A start that is not a raw string prefix, or a prefix cut short.
	task automatic junk_prefix_scan();
		text_q_t txt;
		open_scan();
		if ($urandom_range(0, 3) == 0) begin
			txt = {8'($urandom)};
		end else begin
			txt = prefix_text($urandom_range(0, 4));
			txt = txt[0:$urandom_range(0, txt.size() - 2)];
		end
		if ($urandom_range(0, 1) == 1)
			txt.push_back(8'($urandom));
		send_text(txt, 1'($urandom));
	endtask

	// A begin refused because of the character before it or the end of the text.
	task automatic rejected_scan();
		logic [1:0] why;
		open_scan();
		why = 2'($urandom_range(1, 3));
		put(8'($urandom), 1'b1, why[0], why[1], 1'($urandom));
		repeat ($urandom_range(0, 2))
			put(8'($urandom), 1'b0, 1'($urandom), 1'($urandom), 1'($urandom));
	endtask

	// Fully random items, a quarter of them begins.
	task automatic noise_items();
		open_scan();
		repeat ($urandom_range(1, 3))
			put(8'($urandom), $urandom_range(0, 3) == 0, 1'($urandom), 1'($urandom),
				1'($urandom));
	endtask

	initial begin
		text_q_t txt;
		int      pick;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		ch = '0;
		char_index = '0;
		text_length = '0;
		begin_req = 1'b0;
		prev_ident = 1'b0;
		beyond_end = 1'b0;
		final_char = 1'b0;
		scan_pos = '0;
		scan_len = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Refused starts: past the end of the text, after an identifier
		// character, a byte that opens no prefix, and a text ending inside the prefix.
		put(8'hFF, 1'b1, 1'b0, 1'b1, 1'b0);
		put(CH_UPPER_R, 1'b1, 1'b1, 1'b0, 1'b0);
		put(8'h00, 1'b1, 1'b0, 1'b0, 1'b0);
		put(CH_LOWER_U, 1'b1, 1'b0, 1'b0, 1'b1);

		// An empty-delimiter literal whose closing quote is the last character of the text
		// and sits at the top position, so the end position wraps to zero.
		scan_pos = 32'hFFFF_FFF9;
		scan_len = '1;
		txt = {CH_LOWER_U, CH_EIGHT, CH_UPPER_R, CH_QUOTE, CH_LPAREN, CH_RPAREN, CH_QUOTE};
		send_text(txt, 1'b1);
		// Ignored: no begin after a finished scan.
		put(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);

		// Whitespace in the delimiter is malformed; the text length is reported.
		scan_pos = 32'd100;
		scan_len = '0;
		txt = {CH_UPPER_R, CH_QUOTE, CH_SPACE};
		send_text(txt, 1'b0);

		// A scan dropped by a new begin, followed by a literal whose body has a partial
		// terminator that must restart on the second closing parenthesis.
		scan_len = 32'd5000;
		txt = {CH_UPPER_L, CH_UPPER_R};
		send_text(txt, 1'b0);
		txt = {CH_UPPER_R, CH_QUOTE, CH_EIGHT, CH_LPAREN, CH_RPAREN, CH_EIGHT, CH_RPAREN,
			CH_EIGHT, CH_QUOTE};
		send_text(txt, 1'b0);

		// Random part, with a stretch in the middle where neither side holds back.
		while (board.scanned_chars < TARGET_CHARS) begin
			quiet = board.scanned_chars >= 450 && board.scanned_chars < 650;
			pick = $urandom_range(0, 99);
			if (pick < 60)
				raw_literal_scan();
			else if (pick < 75)
				junk_prefix_scan();
			else if (pick < 85)
				rejected_scan();
			else
				noise_items();
		end
		quiet = 1'b0;
		in_valid <= 1'b0;

		// Drain, then wait for any stray result to show up.
		while (board.pending_ends.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (board.failures == 0 && board.pending_ends.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
